/* rtl/rus_pkg.sv */
package rus_pkg;

  localparam int ADDR_W   = 22;
  localparam int VALUE_W  = 16;
  localparam int SCALE_W  = 4;
  localparam int HEIGHT_W = 10;
  localparam int STRIDE_W = 13;
  localparam int TOP_W    = 10;
  localparam int GRAY_W   = 8;
  localparam int COL_W    = 11;
  localparam int ROW_W    = 10;
  localparam int CHAN_W   = 8;

  localparam int CFG_W     = 13;
  localparam int REG_IDX_W = 3;

  localparam int BAND_ROWS = 8;

  localparam logic [REG_IDX_W-1:0] REG_SCALE        = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_HEIGHT       = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_STRIDE       = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_CAPTION_ON   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_CAPTION_TOP  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_CAPTION_GRAY = 3'd5;

  localparam logic [SCALE_W-1:0]  SCALE_RST  = 4'd1;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 10'd1;
  localparam logic [STRIDE_W-1:0] STRIDE_RST = 13'd720;

  typedef struct packed {
    logic [SCALE_W-1:0]  scale;
    logic [HEIGHT_W-1:0] height;
    logic [STRIDE_W-1:0] stride;
    logic                caption_on;
    logic [TOP_W-1:0]    caption_top;
    logic [GRAY_W-1:0]   caption_gray;
  } rus_cfg_t;

  // One pixel handed to the replicator: first address, packed colour, clamped scale
  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [VALUE_W-1:0] value;
    logic [SCALE_W-1:0] scale;
  } rus_item_t;

  function automatic logic [VALUE_W-1:0] pack565(input logic [CHAN_W-1:0] r,
                                                  input logic [CHAN_W-1:0] g,
                                                  input logic [CHAN_W-1:0] b);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

endpackage

/* rtl/rus_if.sv */
interface rus_in_if;
  import rus_pkg::*;

  logic              valid;
  logic              ready;
  logic [COL_W-1:0]  column;
  logic [ROW_W-1:0]  row;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;
  logic              caption_mask;

  modport source (output valid, column, row, red, green, blue, caption_mask,
                  input ready);
  modport sink   (input valid, column, row, red, green, blue, caption_mask,
                  output ready);
endinterface

interface rus_out_if;
  import rus_pkg::*;

  logic               valid;
  logic               ready;
  logic [ADDR_W-1:0]  pixel_address;
  logic [VALUE_W-1:0] pixel_value;
  logic               last;

  modport source (output valid, pixel_address, pixel_value, last, input ready);
  modport sink   (input valid, pixel_address, pixel_value, last, output ready);
endinterface

/* rtl/rus_expand.sv */
module rus_expand #(
  parameter int MAX_SCALE = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [rus_pkg::STRIDE_W-1:0] stride,
  input  rus_pkg::rus_item_t           item,
  input  logic                        item_valid,
  output logic                        item_ready,
  rus_out_if.source                   pix_out
);
  import rus_pkg::*;

  localparam int CW = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;

  logic               out_valid;
  logic [ADDR_W-1:0]  addr;
  logic [ADDR_W-1:0]  row_addr;
  logic [VALUE_W-1:0] value;
  logic [CW-1:0]      cx;
  logic [CW-1:0]      cy;
  logic [CW-1:0]      s_m1;
  logic               last;

  logic               row_wrap;
  logic               step;
  logic [CW-1:0]      cx_next;
  logic [CW-1:0]      cy_next;
  logic [ADDR_W-1:0]  row_addr_next;
  logic [ADDR_W-1:0]  addr_next;
  logic [ADDR_W-1:0]  stride_ext;
  logic [CW-1:0]      item_s_m1;

  assign item_ready = !out_valid || (pix_out.ready && last);
  assign step       = out_valid && pix_out.ready && !last;
  assign stride_ext = ADDR_W'(stride);
  assign item_s_m1  = CW'(item.scale - SCALE_W'(1));

  // cy runs inside cx; a new cx moves down one physical row
  always_comb begin
    row_wrap      = (cy == s_m1);
    cx_next       = row_wrap ? cx + CW'(1) : cx;
    cy_next       = row_wrap ? '0 : cy + CW'(1);
    row_addr_next = row_wrap ? row_addr + stride_ext : row_addr;
    addr_next     = row_wrap ? row_addr + stride_ext : addr + ADDR_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (item_ready) begin
      out_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready) begin
      addr     <= item.addr;
      row_addr <= item.addr;
      value    <= item.value;
      cx       <= '0;
      cy       <= '0;
      s_m1     <= item_s_m1;
      last     <= (item_s_m1 == '0);
    end else if (step) begin
      addr     <= addr_next;
      row_addr <= row_addr_next;
      cx       <= cx_next;
      cy       <= cy_next;
      last     <= (cx_next == s_m1) && (cy_next == s_m1);
    end
  end

  assign pix_out.valid         = out_valid;
  assign pix_out.pixel_address = addr;
  assign pix_out.pixel_value   = value;
  assign pix_out.last          = last;

endmodule

/* rtl/rotate_upscale_rgb565_scanout_unit.sv */
// Rotating, upscaling RGB565 scanout writer.
// pix_in takes one logical RGB888 pixel with column, row and caption mask on a
// valid/ready handshake. pix_out gives scale*scale buffer words per pixel, each
// with the physical address and the RGB565 value, cx outer and cy inner; the
// final word of a pixel carries last.
// Registers are written through wr_en/wr_index/wr_data; the user must write
// them only while idle, as the block does not enforce it. Pipeline:
// caption/pack/first multiply, then row and column products, then the start
// address sum, then the replicating output register. A pixel passes stages
// A, B and C before its first word enters the output register. Throughput is
// one word per cycle while the receiver is ready; the front stages keep
// taking pixels while the output replicates.
// A stalled receiver holds the current word; the front stages fill and then
// drop ready. Reset empties all stages and loads scale 1, height 1,
// stride 720, caption off.
module rotate_upscale_rgb565_scanout_unit #(
  parameter int MAX_SCALE = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [rus_pkg::REG_IDX_W-1:0] wr_index,
  input  logic [rus_pkg::CFG_W-1:0]     wr_data,
  rus_in_if.sink                        pix_in,
  rus_out_if.source                     pix_out
);
  import rus_pkg::*;

  localparam logic [SCALE_W-1:0] MAX_S = SCALE_W'(MAX_SCALE);
  localparam int BASE_W = COL_W + SCALE_W;

  rus_cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scale        <= SCALE_RST;
      cfg.height       <= HEIGHT_RST;
      cfg.stride       <= STRIDE_RST;
      cfg.caption_on   <= 1'b0;
      cfg.caption_top  <= '0;
      cfg.caption_gray <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_SCALE:        cfg.scale        <= wr_data[SCALE_W-1:0];
        REG_HEIGHT:       cfg.height       <= wr_data[HEIGHT_W-1:0];
        REG_STRIDE:       cfg.stride       <= wr_data[STRIDE_W-1:0];
        REG_CAPTION_ON:   cfg.caption_on   <= wr_data[0];
        REG_CAPTION_TOP:  cfg.caption_top  <= wr_data[TOP_W-1:0];
        REG_CAPTION_GRAY: cfg.caption_gray <= wr_data[GRAY_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage A: clamp scale, caption replace, pack, column product
  logic                a_valid;
  logic [SCALE_W-1:0]  a_scale;
  logic [VALUE_W-1:0]  a_value;
  logic [BASE_W-1:0]   a_base_row;
  logic [ADDR_W-1:0]   a_hrow;

  // Stage B: row and column products
  logic                b_valid;
  logic [SCALE_W-1:0]  b_scale;
  logic [VALUE_W-1:0]  b_value;
  logic [ADDR_W-1:0]   b_prod_row;
  logic [ADDR_W-1:0]   b_prod_col;

  // Stage C: start address
  logic                c_valid;
  rus_item_t           c_item;

  logic                a_ready;
  logic                b_ready;
  logic                c_ready;
  logic                in_take;
  logic                expand_ready;

  logic [SCALE_W-1:0]  s_clamp;
  logic                in_band;
  logic                gray_on;
  logic [VALUE_W-1:0]  in_value;
  logic [ADDR_W-1:0]   in_hrow;

  always_comb begin
    priority if (cfg.scale == '0) begin
      s_clamp = SCALE_W'(1);
    end else if (cfg.scale > MAX_S) begin
      s_clamp = MAX_S;
    end else begin
      s_clamp = cfg.scale;
    end
    // band compare is one bit wider so top + 8 does not wrap
    in_band = ({1'b0, pix_in.row} >= {1'b0, cfg.caption_top}) &&
              ({1'b0, pix_in.row} < ({1'b0, cfg.caption_top} + (TOP_W + 1)'(BAND_ROWS)));
    gray_on = cfg.caption_on && pix_in.caption_mask && in_band;
    in_value = gray_on ? pack565(cfg.caption_gray, cfg.caption_gray, cfg.caption_gray)
                       : pack565(pix_in.red, pix_in.green, pix_in.blue);
    in_hrow  = ADDR_W'(cfg.height) - ADDR_W'(1) - ADDR_W'(pix_in.row);
  end

  assign c_ready      = !c_valid || expand_ready;
  assign b_ready      = !b_valid || c_ready;
  assign a_ready      = !a_valid || b_ready;
  assign pix_in.ready = a_ready;
  assign in_take      = pix_in.valid && a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      if (a_ready) a_valid <= pix_in.valid;
      if (b_ready) b_valid <= a_valid;
      if (c_ready) c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      a_scale    <= s_clamp;
      a_value    <= in_value;
      a_base_row <= BASE_W'(pix_in.column) * BASE_W'(s_clamp);
      a_hrow     <= in_hrow;
    end
    if (b_ready && a_valid) begin
      b_scale    <= a_scale;
      b_value    <= a_value;
      b_prod_row <= ADDR_W'(a_base_row) * ADDR_W'(cfg.stride);
      b_prod_col <= ADDR_W'(a_hrow * ADDR_W'(a_scale));
    end
    if (c_ready && b_valid) begin
      c_item.addr  <= b_prod_row + b_prod_col;
      c_item.value <= b_value;
      c_item.scale <= b_scale;
    end
  end

  rus_expand #(
    .MAX_SCALE (MAX_SCALE)
  ) u_expand (
    .clk        (clk),
    .rst        (rst),
    .stride     (cfg.stride),
    .item       (c_item),
    .item_valid (c_valid),
    .item_ready (expand_ready),
    .pix_out    (pix_out)
  );

endmodule
